// File: rtl/sacn_pkg.sv
// Shared types and constants of the set-associative NRU cache controller.
// No dependencies; every other file of the block imports this package.
package sacn_pkg;

    localparam int WAYS       = 4;
    localparam int SETS       = 64;
    localparam int LINE_BYTES = 16;

    localparam int ADDR_W = 32;
    localparam int WAY_W  = 2;
    localparam int SET_W  = 6;
    localparam int OFF_W  = 4;
    localparam int LINE_W = ADDR_W - OFF_W;
    localparam int TAG_W  = LINE_W - SET_W;

    // first byte address past the backing memory
    localparam logic [ADDR_W:0] MEM_BYTES = 33'd16777216;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              req_type;
    } t_req_item;

    typedef struct packed {
        logic              out_of_range;
        logic              hit;
        logic [WAY_W-1:0]  way;
        logic [SET_W-1:0]  set_index;
        logic [OFF_W-1:0]  byte_offset;
        logic              writeback;
        logic [LINE_W-1:0] writeback_line;
    } t_rsp_item;

    // one set: tags plus valid, dirty and used bits of every way
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0] tag;
        logic [WAYS-1:0]            valid;
        logic [WAYS-1:0]            dirty;
        logic [WAYS-1:0]            used;
    } t_set_row;

    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  way;
        logic              writeback;
        logic [LINE_W-1:0] writeback_line;
    } t_lookup;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

endpackage

// File: rtl/set_assoc_cache_nru_controller.sv
// Top level of the set-associative write-back NRU cache controller.
// Depends on sacn_pkg, sacn_set_mem and sacn_policy.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_in_item  (t_req_item)
//   out      output     o_out_valid / i_out_ready o_out_item (t_rsp_item)
//
// For each access the set row is read at the accept edge and, unless the address
// is out of range, written back at the edge that loads the result register.
// Synchronous active-low reset clears the row valid flops at once; no
// clearing pass is run.
// A result waiting in the output register holds the lookup stage, and a new
// access is taken only once that stage has loaded its result.
module set_assoc_cache_nru_controller (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  sacn_pkg::t_req_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sacn_pkg::t_rsp_item   o_out_item
);
    import sacn_pkg::*;

    t_state    r_state, n_state;
    t_req_item r_req;
    logic      r_out_valid, n_out_valid;
    t_rsp_item r_out, n_out;
    logic      load_out;
    logic      in_fire;
    logic      wr_en;
    logic      oor;
    t_set_row  rd_row;
    t_set_row  new_row;
    t_lookup   lookup;

    assign in_fire = i_in_valid && o_in_ready;
    assign oor     = {1'b0, r_req.address} >= MEM_BYTES;

    sacn_set_mem u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (in_fire),
        .i_rd_set (i_in_item.address[OFF_W +: SET_W]),
        .o_rd_row (rd_row),
        .i_wr_en  (wr_en),
        .i_wr_set (r_req.address[OFF_W +: SET_W]),
        .i_wr_row (new_row)
    );

    sacn_policy u_policy (
        .i_row      (rd_row),
        .i_tag      (r_req.address[ADDR_W-1 -: TAG_W]),
        .i_set      (r_req.address[OFF_W +: SET_W]),
        .i_req_type (r_req.req_type),
        .o_row      (new_row),
        .o_lookup   (lookup)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req <= i_in_item;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        load_out    = 1'b0;
        wr_en       = 1'b0;
        o_in_ready  = 1'b0;
        n_out       = '0;

        if (oor) begin
            n_out.out_of_range = 1'b1;
        end else begin
            n_out.hit            = lookup.hit;
            n_out.way            = lookup.way;
            n_out.set_index      = r_req.address[OFF_W +: SET_W];
            n_out.byte_offset    = r_req.address[OFF_W-1:0];
            n_out.writeback      = lookup.writeback;
            n_out.writeback_line = lookup.writeback_line;
        end

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // advance only when the result register is free this cycle
                if (!r_out_valid || i_out_ready) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    wr_en       = !oor;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: rtl/sacn_set_mem.sv
// Set memory: one row per set, with a registered (synchronous) read.
// Row valid flops stand in for the zero reset of the valid/dirty/used bits.
// Depends on sacn_pkg.
module sacn_set_mem (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rd_en,
    input  logic [sacn_pkg::SET_W-1:0]       i_rd_set,
    output sacn_pkg::t_set_row               o_rd_row,
    input  logic                             i_wr_en,
    input  logic [sacn_pkg::SET_W-1:0]       i_wr_set,
    input  sacn_pkg::t_set_row               i_wr_row
);
    import sacn_pkg::*;

    t_set_row        mem [SETS];
    logic [SETS-1:0] r_row_vld;
    t_set_row        r_rd_data;
    logic            r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_set] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_ok   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_set] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_row_vld[i_rd_set];
            end
        end
    end

    // a row never written reads as all ways invalid, clean and unused
    assign o_rd_row = r_rd_ok ? r_rd_data : '0;

endmodule

// File: rtl/sacn_policy.sv
// Hit detection, NRU victim choice and row update for one set.
// Depends on sacn_pkg.
module sacn_policy (
    input  sacn_pkg::t_set_row               i_row,
    input  logic [sacn_pkg::TAG_W-1:0]       i_tag,
    input  logic [sacn_pkg::SET_W-1:0]       i_set,
    input  logic                             i_req_type,
    output sacn_pkg::t_set_row               o_row,
    output sacn_pkg::t_lookup                o_lookup
);
    import sacn_pkg::*;

    always_comb begin
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic [WAY_W-1:0] victim;
        logic [WAY_W-1:0] way;
        t_set_row         row;

        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && i_row.valid[w] && i_row.tag[w] == i_tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        // highest-numbered way with a clear used bit
        victim = WAY_W'(WAYS - 1);
        for (int w = 0; w < WAYS; w++) begin
            if (!i_row.used[w]) begin
                victim = WAY_W'(w);
            end
        end

        way = hit ? hit_way : victim;
        row = i_row;
        o_lookup = '0;
        o_lookup.hit = hit;
        o_lookup.way = way;

        if (hit) begin
            row.used[way] = 1'b1;
        end else begin
            if (i_row.valid[victim] && i_row.dirty[victim]) begin
                o_lookup.writeback      = 1'b1;
                o_lookup.writeback_line = {i_row.tag[victim], i_set};
            end
            row.tag[victim]   = i_tag;
            row.valid[victim] = 1'b1;
            row.used[victim]  = 1'b1;
            row.dirty[victim] = 1'b0;
        end

        if (i_req_type == REQ_WRITE) begin
            row.dirty[way] = 1'b1;
        end

        if (&row.used) begin
            row.used = '0;
        end

        o_row = row;
    end

endmodule

// File: rtl/sacn_checker.sv
// Port-level checks of the NRU cache controller, bound to the top level.
// Depends on sacn_pkg and set_assoc_cache_nru_controller.
module sacn_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  sacn_pkg::t_req_item   i_in_item,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  sacn_pkg::t_rsp_item   o_out_item
);
    import sacn_pkg::*;

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed before transfer");

    // one access at a time: no accept on the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted during lookup");

    a_oor_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.out_of_range |->
            !o_out_item.hit && !o_out_item.writeback && o_out_item.way == '0
            && o_out_item.set_index == '0 && o_out_item.writeback_line == '0)
        else $error("out-of-range result carries data");

    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.hit |-> !o_out_item.writeback
            && o_out_item.writeback_line == '0)
        else $error("hit reports a writeback");

    a_wb_same_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.writeback |->
            o_out_item.writeback_line[SET_W-1:0] == o_out_item.set_index)
        else $error("writeback line outside the accessed set");

endmodule

bind set_assoc_cache_nru_controller sacn_checker u_sacn_checker (.*);

// File: tb/set_assoc_cache_nru_controller_test.sv
// Self-checking testbench of set_assoc_cache_nru_controller: directed and random accesses,
// checked against a tag, valid, dirty and used-bit model of the NRU cache kept here.
// Depends on sacn_pkg and the controller RTL.
`timescale 1ns / 100ps

module set_assoc_cache_nru_controller_test;
    import sacn_pkg::*;

    typedef enum int {
        PH_RX_STALLS,
        PH_TX_GAPS,
        PH_STREAM
    } t_phase;

    typedef struct {
        t_req_item req;
        t_phase    phase;
    } t_pending;

    localparam int PHASE_ITEMS    = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_TAG        = 16383;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_req_item i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_rsp_item o_out_item;

    set_assoc_cache_nru_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // cache state as the testbench sees it
    logic [TAG_W-1:0] line_tag   [SETS][WAYS];
    bit               line_valid [SETS][WAYS];
    bit               line_dirty [SETS][WAYS];
    bit               line_used  [SETS][WAYS];

    t_pending  pending_reqs[$];
    t_rsp_item expected_rsps[$];
    t_phase    cur_phase = PH_RX_STALLS;
    int        issue_count = 0;
    int        accept_count = 0;
    int        errors = 0;
    int        stall_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int sender_idle_pct(t_phase ph);
        case (ph)
            PH_RX_STALLS: return 22;
            PH_TX_GAPS:   return 72;
            default:      return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct(t_phase ph);
        case (ph)
            PH_RX_STALLS: return 72;
            PH_TX_GAPS:   return 22;
            default:      return 0;
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] line_addr(int tg, int row, int off);
        return {tg[TAG_W-1:0], row[SET_W-1:0], off[OFF_W-1:0]};
    endfunction

    // Look up one access, update the cache state and return the result it gives.
    function automatic t_rsp_item nru_access(t_req_item req);
        t_rsp_item        rsp;
        logic [SET_W-1:0] row;
        logic [TAG_W-1:0] tg;
        int               slot;
        bit               all_used;
        rsp = '0;
        if ({1'b0, req.address} >= MEM_BYTES) begin
            rsp.out_of_range = 1'b1;
            return rsp;
        end
        row  = req.address[OFF_W +: SET_W];
        tg   = req.address[ADDR_W-1 -: TAG_W];
        slot = -1;
        for (int w = 0; w < WAYS; w++)
            if (slot < 0 && line_valid[row][w] && line_tag[row][w] == tg)
                slot = w;
        if (slot >= 0) begin
            rsp.hit = 1'b1;
            line_used[row][slot] = 1'b1;
        end else begin
            // victim: highest way with its used bit clear, top way if none
            slot = WAYS - 1;
            for (int w = 0; w < WAYS; w++)
                if (!line_used[row][w])
                    slot = w;
            if (line_valid[row][slot] && line_dirty[row][slot]) begin
                rsp.writeback      = 1'b1;
                rsp.writeback_line = {line_tag[row][slot], row};
            end
            line_tag[row][slot]   = tg;
            line_valid[row][slot] = 1'b1;
            line_used[row][slot]  = 1'b1;
            line_dirty[row][slot] = 1'b0;
        end
        if (req.req_type == REQ_WRITE)
            line_dirty[row][slot] = 1'b1;
        all_used = 1'b1;
        for (int w = 0; w < WAYS; w++)
            if (!line_used[row][w])
                all_used = 1'b0;
        if (all_used)
            for (int w = 0; w < WAYS; w++)
                line_used[row][w] = 1'b0;
        rsp.way         = slot[WAY_W-1:0];
        rsp.set_index   = row;
        rsp.byte_offset = req.address[OFF_W-1:0];
        return rsp;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        errors++;
        if (errors <= 30)
            $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic queue_req(logic [ADDR_W-1:0] addr, logic kind, t_phase ph);
        t_pending p;
        p.req.address  = addr;
        p.req.req_type = kind;
        p.phase        = ph;
        pending_reqs.push_back(p);
    endtask

    // Mostly a few hot sets and tags so that hits, evictions and writebacks recur.
    function automatic logic [ADDR_W-1:0] random_addr();
        int hot_rows[4];
        int hot_tags[6];
        int pick;
        hot_rows = '{0, 5, 17, 63};
        hot_tags = '{0, 1, 2, 3, 4, MAX_TAG};
        pick = $urandom_range(99);
        if (pick < 70)
            return line_addr(hot_tags[$urandom_range(5)], hot_rows[$urandom_range(3)],
                             $urandom_range(15));
        else if (pick < 85)
            return $urandom_range(32'(MEM_BYTES - 1));
        return $urandom();
    endfunction

    // driver: present items at the falling edge, hold each until its transfer
    always @(negedge i_clk) begin
        t_pending nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || accept_count == issue_count) begin
            if (pending_reqs.size() > 0 &&
                $urandom_range(99) >= sender_idle_pct(pending_reqs[0].phase)) begin
                nxt       = pending_reqs.pop_front();
                cur_phase = nxt.phase;
                issue_count++;
                i_in_item  <= nxt.req;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk)
        i_out_ready <= i_rst_n && ($urandom_range(99) >= receiver_idle_pct(cur_phase));

    // monitor: predict on each request transfer, check each result transfer
    always @(posedge i_clk) begin
        t_rsp_item want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch("result with none expected", o_out_item, 0);
                end else begin
                    want = expected_rsps.pop_front();
                    if (o_out_item.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", o_out_item.out_of_range,
                                        want.out_of_range);
                    if (o_out_item.hit !== want.hit)
                        report_mismatch("hit", o_out_item.hit, want.hit);
                    if (o_out_item.way !== want.way)
                        report_mismatch("way", o_out_item.way, want.way);
                    if (o_out_item.set_index !== want.set_index)
                        report_mismatch("set_index", o_out_item.set_index, want.set_index);
                    if (o_out_item.byte_offset !== want.byte_offset)
                        report_mismatch("byte_offset", o_out_item.byte_offset,
                                        want.byte_offset);
                    if (o_out_item.writeback !== want.writeback)
                        report_mismatch("writeback", o_out_item.writeback, want.writeback);
                    if (o_out_item.writeback_line !== want.writeback_line)
                        report_mismatch("writeback_line", o_out_item.writeback_line,
                                        want.writeback_line);
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_rsps.push_back(nru_access(i_in_item));
                accept_count++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("[set_assoc_cache_nru_controller] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        for (int r = 0; r < SETS; r++)
            for (int w = 0; w < WAYS; w++) begin
                line_tag[r][w]   = '0;
                line_valid[r][w] = 1'b0;
                line_dirty[r][w] = 1'b0;
                line_used[r][w]  = 1'b0;
            end

        // fill set 0, wrap the used bits, then evict dirty lines
        queue_req(line_addr(0, 0, 0), REQ_READ, PH_RX_STALLS);
        queue_req(line_addr(0, 0, 15), REQ_WRITE, PH_RX_STALLS);
        queue_req(line_addr(1, 0, 1), REQ_WRITE, PH_RX_STALLS);
        queue_req(line_addr(2, 0, 2), REQ_READ, PH_RX_STALLS);
        queue_req(line_addr(3, 0, 3), REQ_WRITE, PH_RX_STALLS);
        queue_req(line_addr(4, 0, 4), REQ_READ, PH_RX_STALLS);
        queue_req(line_addr(MAX_TAG, 0, 7), REQ_WRITE, PH_RX_STALLS);
        queue_req(line_addr(2, 0, 8), REQ_READ, PH_RX_STALLS);
        queue_req(line_addr(3, 0, 9), REQ_WRITE, PH_RX_STALLS);
        queue_req(line_addr(1, 0, 0), REQ_READ, PH_RX_STALLS);
        queue_req(line_addr(0, 0, 5), REQ_WRITE, PH_RX_STALLS);
        // top of memory, then just past it and far beyond
        queue_req(line_addr(MAX_TAG, 63, 15), REQ_WRITE, PH_RX_STALLS);
        queue_req(line_addr(MAX_TAG, 63, 0), REQ_READ, PH_RX_STALLS);
        queue_req(32'(MEM_BYTES), REQ_WRITE, PH_RX_STALLS);
        queue_req(32'hFFFF_FFFF, REQ_READ, PH_RX_STALLS);
        queue_req(32'hFFFF_FFFF, REQ_WRITE, PH_RX_STALLS);
        queue_req(32'h8000_0000, REQ_READ, PH_RX_STALLS);
        queue_req(line_addr(MAX_TAG, 63, 15), REQ_READ, PH_RX_STALLS);

        for (int ph = PH_RX_STALLS; ph <= PH_STREAM; ph++)
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_req(random_addr(), $urandom_range(1), t_phase'(ph));

        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (pending_reqs.size() > 0 || i_in_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // a stray result during the drain counts as a mismatch in the monitor
        if (errors == 0 && expected_rsps.size() == 0)
            $display("[set_assoc_cache_nru_controller] OK");
        else
            $display("[set_assoc_cache_nru_controller] ERROR");
        $finish;
    end

endmodule

// File: set_assoc_cache_nru_controller.f
rtl/sacn_pkg.sv
rtl/sacn_set_mem.sv
rtl/sacn_policy.sv
rtl/set_assoc_cache_nru_controller.sv
rtl/sacn_checker.sv
tb/set_assoc_cache_nru_controller_test.sv
